@@ rtl/assert_macros.svh @@
// Assertion macros shared by the frame splitter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cons follows ante in the same cycle outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/lpfs_pkg.sv @@
// Shared types and constants of the length-prefixed frame splitter.
`default_nettype none

package lpfs_pkg;

   // Result kinds
   typedef enum logic [1:0] {
      KindData      = 2'd0,
      KindHeartbeat = 2'd1,
      KindLenErr    = 2'd2
   } lpfs_kind_type;

   // Input actions
   localparam logic ActByte  = 1'b0;
   localparam logic ActClear = 1'b1;

   // Header constants
   localparam logic [31:0] HeartbeatWord = 32'h0000_FFFF;
   localparam logic [31:0] HdrLen        = 32'd4;
   localparam logic [15:0] MaxLenReset   = 16'd4096;

   // Result queue: depth is a power of two, at least four
   localparam int RspDepth   = 8;
   localparam int BurstMax   = 4;

   // One result transaction
   typedef struct packed {
      logic          burst_end;
      logic          last_pkg;
      logic          first_pkg;
      logic [7:0]    data;
      lpfs_kind_type kind;
   } lpfs_rsp_type;

   // Results pushed by one processed item
   typedef struct packed {
      logic [2:0]                  n;
      lpfs_rsp_type [BurstMax-1:0] item;
   } lpfs_push_type;

endpackage

`default_nettype wire

@@ rtl/lpfs_parser.sv @@
// Input register, header/body parser state and result generation.
`default_nettype none
`include "assert_macros.svh"

module lpfs_parser
   import lpfs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [15:0]   csr_wr_data,
   input  wire logic          in_valid,
   input  wire logic          in_action,
   input  wire logic [7:0]    in_byte,
   output logic               in_ready,
   input  wire logic          room,
   output lpfs_push_type      push
);

   logic        in_vld_ff, in_vld_in;
   logic        in_act_ff;
   logic [7:0]  in_byte_ff;
   logic [15:0] max_len_ff;
   logic [7:0]  hdr_ff [3];
   logic [7:0]  hdr_in [3];
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic        in_body_ff, in_body_in;
   logic [15:0] body_rem_ff, body_rem_in;
   logic        err_ff, err_in;
   logic        go;
   logic        accept;
   logic [15:0] rem_dec;
   logic [31:0] be_word;
   logic [31:0] le_word;
   logic [31:0] body_len;

   // Input register advances when empty or when its transaction is processed
   assign go       = in_vld_ff && room;
   assign in_ready = !in_vld_ff || room;
   assign accept   = in_valid && in_ready;

   always_comb begin
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (go) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   // Assemble header words from stored bytes and the current byte
   assign be_word  = {hdr_ff[0], hdr_ff[1], hdr_ff[2], in_byte_ff};
   assign le_word  = {in_byte_ff, hdr_ff[2], hdr_ff[1], hdr_ff[0]};
   assign rem_dec  = body_rem_ff - 16'd1;
   assign body_len = be_word - HdrLen;

   // Step the parser on the registered transaction
   always_comb begin
      hdr_in      = hdr_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      in_body_in  = in_body_ff;
      body_rem_in = body_rem_ff;
      err_in      = err_ff;
      push        = '0;
      if (go) begin
         if (in_act_ff == ActClear) begin
            hdr_cnt_in  = 2'd0;
            in_body_in  = 1'b0;
            body_rem_in = 16'd0;
            err_in      = 1'b0;
         end else if (err_ff) begin
            // drop everything until a clear
         end else if (in_body_ff) begin
            body_rem_in = rem_dec;
            in_body_in  = (rem_dec != 16'd0);
            push.n                   = 3'd1;
            push.item[0].kind        = KindData;
            push.item[0].data        = in_byte_ff;
            push.item[0].last_pkg    = (rem_dec == 16'd0);
            push.item[0].burst_end   = 1'b1;
         end else if (hdr_cnt_ff != 2'd3) begin
            hdr_in[hdr_cnt_ff] = in_byte_ff;
            hdr_cnt_in         = hdr_cnt_ff + 2'd1;
         end else begin
            hdr_cnt_in = 2'd0;
            if (le_word == HeartbeatWord) begin
               push.n                 = 3'd1;
               push.item[0].kind      = KindHeartbeat;
               push.item[0].burst_end = 1'b1;
            end else if (be_word < HdrLen || be_word > {16'd0, max_len_ff}) begin
               err_in                 = 1'b1;
               push.n                 = 3'd1;
               push.item[0].kind      = KindLenErr;
               push.item[0].burst_end = 1'b1;
            end else begin
               push.n                 = 3'd4;
               push.item[0].kind      = KindData;
               push.item[0].data      = hdr_ff[0];
               push.item[0].first_pkg = 1'b1;
               push.item[1].kind      = KindData;
               push.item[1].data      = hdr_ff[1];
               push.item[2].kind      = KindData;
               push.item[2].data      = hdr_ff[2];
               push.item[3].kind      = KindData;
               push.item[3].data      = in_byte_ff;
               push.item[3].last_pkg  = (be_word == HdrLen);
               push.item[3].burst_end = 1'b1;
               if (be_word != HdrLen) begin
                  in_body_in  = 1'b1;
                  body_rem_in = body_len[15:0];
               end
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         max_len_ff  <= MaxLenReset;
         hdr_cnt_ff  <= 2'd0;
         in_body_ff  <= 1'b0;
         body_rem_ff <= 16'd0;
         err_ff      <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         in_body_ff  <= in_body_in;
         body_rem_ff <= body_rem_in;
         err_ff      <= err_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_act_ff  <= in_action;
         in_byte_ff <= in_byte;
      end
      hdr_ff <= hdr_in;
   end

   `ASSERT_IMPLIES(a_body_nonzero, clock, reset, in_body_ff, body_rem_ff != 16'd0, "body active with zero remaining")
   `ASSERT_IMPLIES(a_err_idle, clock, reset, err_ff, !in_body_ff && hdr_cnt_ff == 2'd0, "error set outside header start")
   `ASSERT_IMPLIES(a_push_room, clock, reset, push.n != 3'd0, go, "results pushed without queue room")

endmodule

`default_nettype wire

@@ rtl/lpfs_rsp_queue.sv @@
// Result queue: takes up to four results per cycle, hands out one per cycle on out_ready.
`default_nettype none
`include "assert_macros.svh"

module lpfs_rsp_queue
   import lpfs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  lpfs_push_type      push,
   output logic               room,
   output logic               out_valid,
   input  wire logic          out_ready,
   output lpfs_rsp_type       out_item
);

   localparam int PtrW = $clog2(RspDepth);
   localparam int CntW = PtrW + 1;

   lpfs_rsp_type    mem_ff [RspDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            pop;

   // Room for a whole burst regardless of this cycle's pop
   assign room      = cnt_ff <= CntW'(RspDepth - BurstMax);
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push.n);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      cnt_in    = cnt_ff + CntW'(push.n) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Write the pushed results at consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < BurstMax; i++) begin
         if (3'(i) < push.n) begin
            mem_ff[wr_ptr_ff + PtrW'(i)] <= push.item[i];
         end
      end
   end

   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CntW'(RspDepth), "result queue overfilled")
   `ASSERT_IMPLIES(a_push_fits, clock, reset, push.n != 3'd0, room, "push without room for a burst")

endmodule

`default_nettype wire

@@ rtl/length_prefixed_frame_splitter_unit.sv @@
// Top level of the length-prefixed frame splitter with heartbeat detection.
//
//  channel  direction  fields
//  req_     in         tdata: rx_byte[7:0]; tuser: action
//  rsp_     out        tdata: out_byte[7:0]; tlast: last_of_package;
//                      tuser: kind[1:0], first_of_package, last_of_burst
//  csr_     in         wr_data: max_package_len[15:0], written when wr_en
//
// One input transaction per cycle while req_tready is high; a result passes the
// input register, then the result queue, before it is offered on rsp_.
// A completed header with a valid length pushes four results into the 8-entry
// result queue at once; input is taken while the input register is empty or
// the queue has at least four free slots, and the output side drains one
// result per cycle while rsp_tready is high.
// Synchronous reset clears the parser and the queue and sets the limit to 4096.
`default_nettype none

module length_prefixed_frame_splitter_unit
   import lpfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,  // max_package_len[15:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // rx_byte[7:0]
   input  wire logic        req_tuser,    // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // out_byte[7:0]
   output logic             rsp_tlast,    // last_of_package
   output logic [3:0]       rsp_tuser     // kind[1:0], first_of_package, last_of_burst
);

   lpfs_push_type push;
   lpfs_rsp_type  rsp_item;
   logic          room;

   // Parse incoming transactions
   lpfs_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_action   (req_tuser),
      .in_byte     (req_tdata),
      .in_ready    (req_tready),
      .room        (room),
      .push        (push)
   );

   // Queue results toward the output
   lpfs_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // Map the result onto the stream fields
   assign rsp_tdata = rsp_item.data;
   assign rsp_tlast = rsp_item.last_pkg;
   assign rsp_tuser = {rsp_item.burst_end, rsp_item.first_pkg, rsp_item.kind};

endmodule

`default_nettype wire
